>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/wasmstk_pkg.sv
`timescale 1ns / 1ps

package wasmstk_pkg;

    // Instruction codes
    localparam logic [2:0] FN_CONST = 3'd0;
    localparam logic [2:0] FN_ADD   = 3'd1;
    localparam logic [2:0] FN_REM   = 3'd2;
    localparam logic [2:0] FN_EQZ   = 3'd3;
    localparam logic [2:0] FN_LES   = 3'd4;
    localparam logic [2:0] FN_DROP  = 3'd5;
    localparam logic [2:0] FN_LGET  = 3'd6;
    localparam logic [2:0] FN_LSET  = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_BADLOC = 3'd4;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;
    localparam int LIU_W   = 5;

    // Register map
    localparam logic [2:0]       ADDR_LOCALS = 3'd0;
    localparam logic [LIU_W-1:0] LIU_RESET   = 5'd16;

    typedef struct packed {
        logic [2:0]        func;
        logic [DATA_W-1:0] immediate;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0]  top_value;
        logic [DEPTH_W-1:0] stack_depth;
        logic [2:0]         status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/wasm_i32_stack_execute.sv
`timescale 1ns / 1ps

// Executes one decoded WebAssembly i32 instruction per input word against an
// operand stack held in RAM (top entry cached in a register) and a local file
// in RAM whose entries read as zero until first written. One word is in work at
// a time; the input stalls from acceptance until the result is loaded into the
// output register, which then waits for the consumer while the next word is
// taken. A faulting instruction goes from acceptance straight to the done
// state; const and eqz pass through execute; drop, local.get and local.set
// through execute and read wait; add and le_s through execute, read wait and
// write-back; rem_u adds the 32-step shift-subtract loop between read wait and
// write-back, and that loop runs on the same 33-bit adder that serves add and
// le_s.
// Configuration register locals_in_use sits at byte address 0.
module wasm_i32_stack_execute
    import wasmstk_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int LA_W = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
    localparam logic [SP_W-1:0]   SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [DATA_W-1:0] SIGN    = {1'b1, {(DATA_W-1){1'b0}}};

    t_state                r_state, n_state;
    logic [2:0]            r_func, n_func;
    logic [DATA_W-1:0]     r_imm, n_imm;
    logic [2:0]            r_status, n_status;
    logic [SP_W-1:0]       r_sp, n_sp;
    logic [DATA_W-1:0]     r_top, n_top;
    logic [DATA_W-1:0]     r_acc, n_acc;
    logic [DATA_W-1:0]     r_dvd, n_dvd;
    logic [4:0]            r_cnt, n_cnt;
    logic [LIU_W-1:0]      r_liu;
    logic [LOCAL_SLOTS-1:0] r_lvalid;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic              in_acc;
    logic              out_load;
    logic              cfg_wr;
    logic [2:0]        chk_status;
    logic              loc_ok;
    logic [SP_W-1:0]   sp_m1, sp_m2;

    logic              s_we;
    logic [SA_W-1:0]   s_waddr, s_raddr;
    logic [DATA_W-1:0] s_wdata, s_rdata;
    logic              l_we;
    logic [LA_W-1:0]   l_waddr, l_raddr;
    logic [DATA_W-1:0] l_wdata, l_rdata;
    logic [DATA_W-1:0] lget_val;

    logic [DATA_W:0]   u_x, u_y;
    logic              u_sub;
    logic [DATA_W+1:0] u_sum;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign sp_m1      = r_sp - SP_W'(1);
    assign sp_m2      = r_sp - SP_W'(2);
    assign lget_val   = r_lvalid[r_imm[LA_W-1:0]] ? l_rdata : '0;

    // Shared adder: add, signed compare and divide step
    assign u_sum = {1'b0, u_x} + {1'b0, (u_sub ? ~u_y : u_y)} + (DATA_W+2)'(u_sub);

    // Check the incoming word for faults in priority order
    assign loc_ok = (i_in_word.immediate < DATA_W'(r_liu)) &&
                    (i_in_word.immediate < DATA_W'(LOCAL_SLOTS));

    always_comb begin
        chk_status = ST_OK;
        case (i_in_word.func) inside
            FN_CONST: begin
                if (r_sp == SP_FULL) chk_status = ST_OVER;
            end
            FN_ADD, FN_LES: begin
                if (r_sp < SP_W'(2)) chk_status = ST_UNDER;
            end
            FN_REM: begin
                if (r_sp < SP_W'(2))  chk_status = ST_UNDER;
                else if (r_top == '0) chk_status = ST_DIVZ;
            end
            FN_EQZ, FN_DROP: begin
                if (r_sp == '0) chk_status = ST_UNDER;
            end
            FN_LGET: begin
                if (r_sp == SP_FULL) chk_status = ST_OVER;
                else if (!loc_ok)    chk_status = ST_BADLOC;
            end
            default: begin
                if (r_sp == '0)   chk_status = ST_UNDER;
                else if (!loc_ok) chk_status = ST_BADLOC;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = (chk_status != ST_OK) ? S_DONE : S_EXEC;
            end
            S_EXEC: begin
                if (r_func == FN_CONST || r_func == FN_EQZ) n_state = S_DONE;
                else                                        n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                if (r_func == FN_REM)                           n_state = S_DIV;
                else if (r_func == FN_ADD || r_func == FN_LES) n_state = S_WB;
                else                                            n_state = S_DONE;
            end
            S_DIV: begin
                if (r_cnt == 5'd31) n_state = S_WB;
            end
            S_WB: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory strobes and shared adder operands
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_sp[SA_W-1:0];
        s_wdata = r_acc;
        s_raddr = sp_m2[SA_W-1:0];
        l_we    = 1'b0;
        l_waddr = r_imm[LA_W-1:0];
        l_wdata = r_top;
        l_raddr = r_imm[LA_W-1:0];
        u_x     = '0;
        u_y     = '0;
        u_sub   = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                case (r_func) inside
                    FN_CONST: begin
                        s_we    = 1'b1;
                        s_wdata = r_imm;
                    end
                    FN_EQZ: begin
                        s_we    = 1'b1;
                        s_waddr = sp_m1[SA_W-1:0];
                        s_wdata = DATA_W'(r_top == '0);
                    end
                    FN_LSET: begin
                        l_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_RDWAIT: begin
                case (r_func) inside
                    FN_ADD: begin
                        u_x = {1'b0, s_rdata};
                        u_y = {1'b0, r_top};
                    end
                    FN_LES: begin
                        u_x   = {1'b0, r_top ^ SIGN};
                        u_y   = {1'b0, s_rdata ^ SIGN};
                        u_sub = 1'b1;
                    end
                    FN_LGET: begin
                        s_we    = 1'b1;
                        s_wdata = lget_val;
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                u_x   = {r_acc, r_dvd[DATA_W-1]};
                u_y   = {1'b0, r_top};
                u_sub = 1'b1;
            end
            S_WB: begin
                s_we    = 1'b1;
                s_waddr = sp_m2[SA_W-1:0];
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_func   = r_func;
        n_imm    = r_imm;
        n_status = r_status;
        n_sp     = r_sp;
        n_top    = r_top;
        n_acc    = r_acc;
        n_dvd    = r_dvd;
        n_cnt    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_in_word.func;
                    n_imm    = i_in_word.immediate;
                    n_status = chk_status;
                end
            end
            S_EXEC: begin
                case (r_func) inside
                    FN_CONST: begin
                        n_sp  = r_sp + SP_W'(1);
                        n_top = r_imm;
                    end
                    FN_EQZ:  n_top = DATA_W'(r_top == '0);
                    FN_DROP, FN_LSET: n_sp = sp_m1;
                    default: ;
                endcase
            end
            S_RDWAIT: begin
                case (r_func) inside
                    FN_ADD: n_acc = u_sum[DATA_W-1:0];
                    FN_LES: n_acc = DATA_W'(u_sum[DATA_W+1]);
                    FN_REM: begin
                        n_acc = '0;
                        n_dvd = s_rdata;
                        n_cnt = '0;
                    end
                    FN_LGET: begin
                        n_top = lget_val;
                        n_sp  = r_sp + SP_W'(1);
                    end
                    FN_DROP, FN_LSET: n_top = (r_sp == '0) ? '0 : s_rdata;
                    default: ;
                endcase
            end
            S_DIV: begin
                n_acc = u_sum[DATA_W+1] ? u_sum[DATA_W-1:0] : u_x[DATA_W-1:0];
                n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
            end
            S_WB: begin
                n_top = r_acc;
                n_sp  = sp_m1;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_top       <= '0;
            r_lvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_top   <= n_top;
            if (l_we) begin
                r_lvalid[l_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_imm    <= n_imm;
        r_status <= n_status;
        r_acc    <= n_acc;
        r_dvd    <= n_dvd;
        r_cnt    <= n_cnt;
        if (out_load) begin
            r_out_word.top_value   <= r_top;
            r_out_word.stack_depth <= DEPTH_W'(r_sp);
            r_out_word.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LOCALS);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_liu <= LIU_RESET;
        end else if (cfg_wr) begin
            r_liu <= pwdata[LIU_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_LOCALS: prdata = 32'(r_liu);
            default:     prdata = '0;
        endcase
    end

    // Operand stack
    wasmstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Local slots
    wasmstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LOCAL_SLOTS)
    ) u_local_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

endmodule

>>> rtl/core/wasmstk_ram.sv
`timescale 1ns / 1ps

module wasmstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wasmstk_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wasmstk_chk
    import wasmstk_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // One word in work at a time: stall right after an accept
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Hold a stalled output word
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // Empty stack reports a zero top
    `ASSERT_IMP(a_empty_top, i_clk, i_rst_n, (STACK_DEPTH < 128) && o_out_valid && (o_out_word.stack_depth == 7'd0), o_out_word.top_value == 32'd0)

    // Underflow only with fewer than two entries
    `ASSERT_IMP(a_under_depth, i_clk, i_rst_n, o_out_valid && (o_out_word.status == ST_UNDER), o_out_word.stack_depth < 7'd2)

endmodule

bind wasm_i32_stack_execute wasmstk_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_wasmstk_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wasmstk_pkg::*;

    localparam int STK_MAX      = 64;
    localparam int LOC_MAX      = 16;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    // Shadow copy of the operand stack and locals; predicts one status word per instruction
    class stack_shadow;
        logic [31:0] operands [STK_MAX];
        logic [31:0] locals [LOC_MAX];
        int          depth;
        int          liu;
        t_out_word   predicted_words [$];
        int          mismatches;
        int          instrs;
        int          results;
        int          peak;
        int          status_seen [5];

        function new();
            depth = 0;
            liu = LIU_RESET;
            mismatches = 0;
            instrs = 0;
            results = 0;
            peak = 0;
            foreach (operands[i]) operands[i] = '0;
            foreach (locals[i]) locals[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH %0d: %s", mismatches, msg);
            end
        endfunction

        // Index is good only below min(locals_in_use, slot count), full 32 bits compared
        function bit slot_ok(logic [31:0] idx);
            int lim;
            lim = (liu > LOC_MAX) ? LOC_MAX : liu;
            return idx < 32'(lim);
        endfunction

        // Run one accepted instruction and queue the word it should produce
        function void exec_instr(t_in_word w);
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            logic [2:0]  st;
            int          d;
            t_out_word   o;
            d = depth;
            st = ST_OK;
            case (w.func)
                FN_CONST: begin
                    if (d >= STK_MAX) begin
                        st = ST_OVER;
                    end else begin
                        operands[d] = w.immediate;
                        d++;
                    end
                end
                FN_ADD, FN_REM, FN_LES: begin
                    if (d < 2) begin
                        st = ST_UNDER;
                    end else begin
                        a = operands[d-2];
                        b = operands[d-1];
                        if (w.func == FN_REM && b == 0) begin
                            st = ST_DIVZ;
                        end else begin
                            if (w.func == FN_ADD) r = a + b;
                            else if (w.func == FN_REM) r = a % b;
                            else r = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
                            operands[d-2] = r;
                            d--;
                        end
                    end
                end
                FN_EQZ: begin
                    if (d < 1) st = ST_UNDER;
                    else operands[d-1] = (operands[d-1] == 0) ? 32'd1 : 32'd0;
                end
                FN_DROP: begin
                    if (d < 1) st = ST_UNDER;
                    else d--;
                end
                FN_LGET: begin
                    if (d >= STK_MAX) begin
                        st = ST_OVER;
                    end else if (!slot_ok(w.immediate)) begin
                        st = ST_BADLOC;
                    end else begin
                        operands[d] = locals[w.immediate[3:0]];
                        d++;
                    end
                end
                default: begin
                    if (d < 1) begin
                        st = ST_UNDER;
                    end else if (!slot_ok(w.immediate)) begin
                        st = ST_BADLOC;
                    end else begin
                        locals[w.immediate[3:0]] = operands[d-1];
                        d--;
                    end
                end
            endcase
            depth = d;
            if (d > peak) peak = d;
            instrs++;
            status_seen[st]++;
            o.top_value = (d > 0) ? operands[d-1] : 32'd0;
            o.stack_depth = d[DEPTH_W-1:0];
            o.status = st;
            predicted_words.push_back(o);
        endfunction

        // Compare one accepted output word with the oldest prediction
        function void check_out(t_out_word got);
            t_out_word e;
            results++;
            if (predicted_words.size() == 0) begin
                flag($sformatf("unexpected word: top=%h depth=%0d status=%0d",
                    got.top_value, got.stack_depth, got.status));
                return;
            end
            e = predicted_words.pop_front();
            if (got.top_value !== e.top_value || got.stack_depth !== e.stack_depth ||
                got.status !== e.status) begin
                flag($sformatf("expected top=%h depth=%0d status=%0d, got top=%h depth=%0d status=%0d",
                    e.top_value, e.stack_depth, e.status,
                    got.top_value, got.stack_depth, got.status));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stack_shadow sb;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          cycles = 0;
    int          depth_goal = 0;
    int          goal_tries = 0;
    int          mid_liu;
    logic [31:0] rd;

    wasm_i32_stack_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: give up well past the slowest legal run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still pending",
                cycles, sb.predicted_words.size());
            $display("** wasm_i32_stack_execute: FAILED **");
            $finish;
        end
    end

    // Output side: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (holds_served < hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check every output word taken
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_out(o_out_word);
        end
    end

    // Offer one word, hold it until taken, then update the shadow
    task automatic send_word(input logic [2:0] f, input logic [31:0] imm);
        t_in_word w;
        w.func = f;
        w.immediate = imm;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.exec_instr(w);
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.predicted_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_locals(input logic [4:0] n);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_LOCALS;
        pwdata <= {27'd0, n};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.liu = n;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_locals(output logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_LOCALS;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        v = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_slot();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return $urandom_range(0, 17);
        if (r == 8) return $urandom_range(0, 31);
        return $urandom;
    endfunction

    // Walk the depth toward a goal (empty, full or in between), then pick another;
    // at the empty and full goals, push past the edge a few times
    function automatic t_in_word pick_word();
        t_in_word w;
        bit       grow;
        int       d;
        int       r;
        d = sb.depth;
        w.immediate = $urandom;
        if ($urandom_range(0, 99) < 10) begin
            w.func = 3'($urandom_range(0, 7));
            return w;
        end
        if (d == depth_goal) begin
            if (goal_tries > 0) begin
                goal_tries--;
                grow = (depth_goal == STK_MAX);
            end else begin
                r = $urandom_range(0, 9);
                depth_goal = (r < 3) ? STK_MAX : (r < 5) ? 0 : $urandom_range(1, STK_MAX - 1);
                goal_tries = (depth_goal == 0 || depth_goal == STK_MAX) ?
                    $urandom_range(1, 3) : 0;
                grow = $urandom_range(0, 1);
            end
        end else begin
            grow = ((d < depth_goal) == ($urandom_range(0, 99) < 85));
        end
        if ($urandom_range(0, 9) == 0) begin
            w.func = FN_EQZ;
        end else if (grow) begin
            if ($urandom_range(0, 9) < 7) begin
                w.func = FN_CONST;
                case ($urandom_range(0, 9))
                    0: w.immediate = 32'h0000_0000;
                    1: w.immediate = 32'h0000_0001;
                    2: w.immediate = 32'hFFFF_FFFF;
                    3: w.immediate = 32'h8000_0000;
                    4: w.immediate = 32'h7FFF_FFFF;
                    5, 6: w.immediate = $urandom_range(0, 15);
                    default: w.immediate = $urandom;
                endcase
            end else begin
                w.func = FN_LGET;
                w.immediate = pick_slot();
            end
        end else begin
            r = $urandom_range(0, 99);
            if (r < 25) w.func = FN_ADD;
            else if (r < 45) w.func = FN_REM;
            else if (r < 65) w.func = FN_LES;
            else if (r < 80) w.func = FN_DROP;
            else begin
                w.func = FN_LSET;
                w.immediate = pick_slot();
            end
        end
        return w;
    endfunction

    // Idle the block, set locals_in_use, then stream random words
    task automatic run_phase(input int liu_val, input int idle_p, input int stall_p,
                             input int n, input bit hold);
        t_in_word w;
        drain();
        write_locals(liu_val[4:0]);
        read_locals(rd);
        if (rd !== {27'd0, liu_val[4:0]}) begin
            sb.flag($sformatf("locals_in_use readback: expected %0d, got %h", liu_val, rd));
        end
        send_idle_pct = idle_p;
        stall_pct = stall_p;
        if (hold) hold_requests++;
        repeat (n) begin
            w = pick_word();
            send_word(w.func, w.immediate);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mid_liu = $urandom_range(2, 15);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_locals(rd);
        if (rd !== {27'd0, LIU_RESET}) begin
            sb.flag($sformatf("locals_in_use after reset: expected %0d, got %h", LIU_RESET, rd));
        end

        // Empty stack: every pop underflows, underflow wins over a bad index
        send_word(FN_DROP, 32'h0);
        send_word(FN_ADD, 32'h0);
        send_word(FN_LSET, 32'hFFFF_FFFF);
        send_word(FN_EQZ, 32'h0);
        // Locals read zero before any write; indexes past the limit are bad
        send_word(FN_LGET, 32'h0);
        send_word(FN_EQZ, 32'h0);
        send_word(FN_LGET, 32'h10);
        send_word(FN_LGET, 32'h0001_0000);
        // Wrapping add, signed compare at both extremes
        send_word(FN_CONST, 32'hFFFF_FFFF);
        send_word(FN_ADD, 32'h0);
        send_word(FN_CONST, 32'h8000_0000);
        send_word(FN_LES, 32'h0);
        send_word(FN_CONST, 32'h7FFF_FFFF);
        send_word(FN_LES, 32'h0);
        // Zero divisor leaves the stack alone
        send_word(FN_CONST, 32'h0);
        send_word(FN_REM, 32'h0);
        send_word(FN_DROP, 32'h0);
        send_word(FN_CONST, 32'hFFFF_FFFF);
        send_word(FN_CONST, 32'h7);
        send_word(FN_REM, 32'h0);
        // Highest slot, then one past it
        send_word(FN_LSET, 32'hF);
        send_word(FN_LSET, 32'h10);
        send_word(FN_LGET, 32'hF);

        run_phase(1, 0, 0, 105, 1'b0);
        run_phase(0, 49, 0, 105, 1'b0);
        run_phase(31, 0, 49, 105, 1'b0);
        run_phase(mid_liu, 24, 24, 105, 1'b0);
        run_phase(16, 0, 0, 20, 1'b1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d instructions (%0d words checked), locals_in_use 16/1/0/31/%0d/16, peak depth %0d, one %0d-cycle output hold-off",
            sb.instrs, sb.results, mid_liu, sb.peak, HOLD_CYCLES);
        $display("Status mix: ok %0d, underflow %0d, overflow %0d, zero divisor %0d, bad slot %0d; mismatches %0d",
            sb.status_seen[ST_OK], sb.status_seen[ST_UNDER], sb.status_seen[ST_OVER],
            sb.status_seen[ST_DIVZ], sb.status_seen[ST_BADLOC], sb.mismatches);
        if (sb.mismatches == 0 && sb.predicted_words.size() == 0) begin
            $display("** wasm_i32_stack_execute: PASSED **");
        end else begin
            $display("** wasm_i32_stack_execute: FAILED **");
        end
        $finish;
    end

endmodule

>>> wasm_i32_stack_execute.f
+incdir+rtl/core
rtl/core/wasmstk_pkg.sv
rtl/core/wasmstk_ram.sv
rtl/core/wasm_i32_stack_execute.sv
rtl/core/wasmstk_chk.sv
tb/testbench.sv
